// ===== sv/swes_pkg.sv =====
// Shared types, codes and constants of the stop-and-wait event sender.
package swes_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  localparam logic [1:0] EV_RUN_STARTED   = 2'd1;
  localparam logic [1:0] EV_RUN_COMPLETED = 2'd2;

  localparam logic [1:0] RK_ACK       = 2'd0;
  localparam logic [1:0] RK_DUPLICATE = 2'd1;
  localparam logic [1:0] RK_NACK      = 2'd2;
  localparam logic [1:0] RK_IGNORE    = 2'd3;

  localparam logic REG_RETRY_INTERVAL      = 1'b0;
  localparam logic REG_NACK_RETRY_INTERVAL = 1'b1;

  localparam logic [31:0] RETRY_INTERVAL_RESET      = 32'd1000;
  localparam logic [31:0] NACK_RETRY_INTERVAL_RESET = 32'd2000;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

  typedef struct packed {
    logic [1:0]  event_type;
    logic [15:0] completed_runs;
    logic [31:0] session_id;
    logic [31:0] run_id;
  } entry_t;

endpackage

// ===== sv/swes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/swes_ctrl.sv =====
// Controller: sequences accept and execute of one beat at a time.
module swes_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swes_pkg::sts_t     sts,
  output swes_pkg::cmd_t     cmd
);

  swes_pkg::state_t state_r;
  swes_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swes_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      swes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = swes_pkg::ST_EXEC;
        end
      end
      swes_pkg::ST_EXEC: begin
        // hold while the result register is still occupied
        if (!sts.out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = swes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swes_dp.sv =====
// Datapath: event ring, send timing, reply matching and result register.
module swes_dp #(
  parameter int QUEUE_DEPTH = swes_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swes_pkg::cmd_t     cmd,
  output swes_pkg::sts_t     sts,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_event_type,
  input  logic [31:0]        in_session_id,
  input  logic [31:0]        in_run_id,
  input  logic [15:0]        in_completed_runs,
  input  logic [1:0]         in_reply_kind,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_enqueue_accepted,
  output logic               out_send_now,
  output logic [1:0]         out_send_type,
  output logic [31:0]        out_send_session,
  output logic [31:0]        out_send_run,
  output logic [15:0]        out_send_completed,
  output logic               out_delivered,
  output logic [1:0]         out_delivery_result,
  output logic [31:0]        out_delivery_run,
  output logic [CNT_W-1:0]   out_queued,
  output logic               out_awaiting_ack
);

  localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // captured beat
  logic [1:0]  op_r;
  logic [31:0] now_r;
  logic [1:0]  etype_r;
  logic [31:0] session_r;
  logic [31:0] run_r;
  logic [15:0] completed_r;
  logic [1:0]  kind_r;

  // configuration and sender state
  logic [31:0]      retry_r;
  logic [31:0]      nack_retry_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             pend_r, pend_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [31:0]      act_r, act_nxt;

  // result register
  logic             out_valid_r;
  logic             enq_acc_r, enq_acc_nxt;
  logic             send_r, send_nxt;
  logic [1:0]       send_type_r, send_type_nxt;
  logic [31:0]      send_session_r, send_session_nxt;
  logic [31:0]      send_run_r, send_run_nxt;
  logic [15:0]      send_completed_r, send_completed_nxt;
  logic             deliv_r, deliv_nxt;
  logic [1:0]       deliv_result_r, deliv_result_nxt;
  logic [31:0]      deliv_run_r, deliv_run_nxt;
  logic [CNT_W-1:0] queued_r;
  logic             awaiting_r;

  swes_pkg::entry_t front;
  swes_pkg::entry_t wr_entry;
  logic             ring_we;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [31:0]      elapsed;
  logic             empty;
  logic             enq_ok;
  logic             tick_send;
  logic             reply_hit;

  swes_ram #(
    .WIDTH ($bits(swes_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (tail),
    .wr_data (wr_entry),
    .rd_addr (head_r),
    .rd_data (front)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_opcode;
      now_r       <= in_now_ms;
      etype_r     <= in_event_type;
      session_r   <= in_session_id;
      run_r       <= in_run_id;
      completed_r <= in_completed_runs;
      kind_r      <= in_reply_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r      <= swes_pkg::RETRY_INTERVAL_RESET;
      nack_retry_r <= swes_pkg::NACK_RETRY_INTERVAL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == swes_pkg::REG_RETRY_INTERVAL) begin
        retry_r <= cfg_data;
      end
      if (cfg_index == swes_pkg::REG_NACK_RETRY_INTERVAL) begin
        nack_retry_r <= cfg_data;
      end
    end
  end

  always_comb begin
    empty    = (fill_r == '0);
    tail_sum = {1'b0, head_r} + {1'b0, fill_r[PTR_W-1:0]};
    tail     = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                       : tail_sum[PTR_W-1:0];
    elapsed  = now_r - last_r;

    enq_ok = (op_r == swes_pkg::OP_ENQUEUE)
             && (etype_r == swes_pkg::EV_RUN_STARTED
                 || etype_r == swes_pkg::EV_RUN_COMPLETED)
             && (session_r != '0) && (run_r != '0) && (fill_r != FULL_CNT);
    tick_send = (op_r == swes_pkg::OP_TICK) && !empty
                && (!pend_r || (elapsed >= act_r));
    reply_hit = (op_r == swes_pkg::OP_REPLY) && !empty && (run_r != '0)
                && (run_r == front.run_id) && (kind_r != swes_pkg::RK_IGNORE);

    wr_entry.event_type     = etype_r;
    wr_entry.completed_runs = completed_r;
    wr_entry.session_id     = session_r;
    wr_entry.run_id         = run_r;
    ring_we                 = cmd.exec && enq_ok;

    head_nxt           = head_r;
    fill_nxt           = fill_r;
    pend_nxt           = pend_r;
    last_nxt           = last_r;
    act_nxt            = act_r;
    enq_acc_nxt        = 1'b0;
    send_nxt           = 1'b0;
    send_type_nxt      = '0;
    send_session_nxt   = '0;
    send_run_nxt       = '0;
    send_completed_nxt = '0;
    deliv_nxt          = 1'b0;
    deliv_result_nxt   = '0;
    deliv_run_nxt      = '0;

    if (enq_ok) begin
      fill_nxt    = fill_r + CNT_W'(1);
      enq_acc_nxt = 1'b1;
    end

    if (op_r == swes_pkg::OP_TICK && empty) begin
      pend_nxt = 1'b0;
    end
    if (tick_send) begin
      send_nxt           = 1'b1;
      send_type_nxt      = front.event_type;
      send_session_nxt   = front.session_id;
      send_run_nxt       = front.run_id;
      send_completed_nxt = front.completed_runs;
      pend_nxt           = 1'b1;
      last_nxt           = now_r;
    end

    if (reply_hit) begin
      deliv_nxt        = 1'b1;
      deliv_result_nxt = kind_r;
      deliv_run_nxt    = run_r;
      last_nxt         = now_r;
      if (kind_r == swes_pkg::RK_NACK) begin
        pend_nxt = 1'b1;
        act_nxt  = nack_retry_r;
      end else begin
        // pop the front
        head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + PTR_W'(1);
        fill_nxt = fill_r - CNT_W'(1);
        pend_nxt = 1'b0;
        act_nxt  = retry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      last_r      <= '0;
      act_r       <= swes_pkg::RETRY_INTERVAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r      <= head_nxt;
        fill_r      <= fill_nxt;
        pend_r      <= pend_nxt;
        last_r      <= last_nxt;
        act_r       <= act_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      enq_acc_r        <= enq_acc_nxt;
      send_r           <= send_nxt;
      send_type_r      <= send_type_nxt;
      send_session_r   <= send_session_nxt;
      send_run_r       <= send_run_nxt;
      send_completed_r <= send_completed_nxt;
      deliv_r          <= deliv_nxt;
      deliv_result_r   <= deliv_result_nxt;
      deliv_run_r      <= deliv_run_nxt;
      queued_r         <= fill_nxt;
      awaiting_r       <= pend_nxt;
    end
  end

  assign sts.out_stall = out_valid_r && !out_ready;

  assign out_valid            = out_valid_r;
  assign out_enqueue_accepted = enq_acc_r;
  assign out_send_now         = send_r;
  assign out_send_type        = send_type_r;
  assign out_send_session     = send_session_r;
  assign out_send_run         = send_run_r;
  assign out_send_completed   = send_completed_r;
  assign out_delivered        = deliv_r;
  assign out_delivery_result  = deliv_result_r;
  assign out_delivery_run     = deliv_run_r;
  assign out_queued           = queued_r;
  assign out_awaiting_ack     = awaiting_r;

endmodule

// ===== sv/stop_and_wait_event_sender.sv =====
// Top level of the stop-and-wait event sender.
// Holds up to QUEUE_DEPTH events in a ring RAM and releases them one at a time: each input
// beat is an enqueue, a time tick, a decoded reply or an unused opcode, and gives exactly
// one result beat. A beat is accepted in ST_IDLE and executed in ST_EXEC, where the front
// entry arrives from the ring RAM's registered read port; no new beat is taken before the
// last has executed. A finished result waits in the output register while the next beat is
// accepted; execution of that beat holds until the result is taken. Retry intervals must
// be written via cfg_ port only while the block is idle; the block does not enforce it.
// An ACK or DUPLICATE loads retry_r, a NACK nack_retry_r. No clearing pass follows reset.
module stop_and_wait_event_sender #(
  parameter int QUEUE_DEPTH = swes_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_event_type,
  input  logic [31:0]        in_session_id,
  input  logic [31:0]        in_run_id,
  input  logic [15:0]        in_completed_runs,
  input  logic [1:0]         in_reply_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_enqueue_accepted,
  output logic               out_send_now,
  output logic [1:0]         out_send_type,
  output logic [31:0]        out_send_session,
  output logic [31:0]        out_send_run,
  output logic [15:0]        out_send_completed,
  output logic               out_delivered,
  output logic [1:0]         out_delivery_result,
  output logic [31:0]        out_delivery_run,
  output logic [CNT_W-1:0]   out_queued,
  output logic               out_awaiting_ack,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  swes_pkg::cmd_t cmd;
  swes_pkg::sts_t sts;

  swes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swes_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_now_ms            (in_now_ms),
    .in_event_type        (in_event_type),
    .in_session_id        (in_session_id),
    .in_run_id            (in_run_id),
    .in_completed_runs    (in_completed_runs),
    .in_reply_kind        (in_reply_kind),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_enqueue_accepted (out_enqueue_accepted),
    .out_send_now         (out_send_now),
    .out_send_type        (out_send_type),
    .out_send_session     (out_send_session),
    .out_send_run         (out_send_run),
    .out_send_completed   (out_send_completed),
    .out_delivered        (out_delivered),
    .out_delivery_result  (out_delivery_result),
    .out_delivery_run     (out_delivery_run),
    .out_queued           (out_queued),
    .out_awaiting_ack     (out_awaiting_ack)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queued <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted before execute");

  a_send_marks_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_now) |-> (out_awaiting_ack && out_queued != '0))
    else $error("send without pending acknowledgement");

  a_enqueue_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_enqueue_accepted)
      |-> (out_queued != '0 && !out_send_now && !out_delivered))
    else $error("enqueue result mixed with send or delivery");

endmodule

// ===== test/tb_stop_and_wait_event_sender.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stop-and-wait event sender: directed cases, random traffic.
module tb_stop_and_wait_event_sender;

  localparam int         DEPTH       = swes_pkg::QUEUE_DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_INVALID  = 2'd3;
  localparam int         MAX_REPORTS = 10;
  localparam logic [31:0] T0         = 32'hFFFF_FF00;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [1:0]  event_type;
    logic [31:0] session_id;
    logic [31:0] run_id;
    logic [15:0] completed_runs;
    logic [1:0]  reply_kind;
  } beat_t;

  typedef struct packed {
    logic        enqueue_accepted;
    logic        send_now;
    logic [1:0]  send_type;
    logic [31:0] send_session;
    logic [31:0] send_run;
    logic [15:0] send_completed;
    logic        delivered;
    logic [1:0]  delivery_result;
    logic [31:0] delivery_run;
    logic [3:0]  queued;
    logic        awaiting_ack;
  } outcome_t;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode         = '0;
  logic [31:0] in_now_ms         = '0;
  logic [1:0]  in_event_type     = '0;
  logic [31:0] in_session_id     = '0;
  logic [31:0] in_run_id         = '0;
  logic [15:0] in_completed_runs = '0;
  logic [1:0]  in_reply_kind     = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic        out_enqueue_accepted;
  logic        out_send_now;
  logic [1:0]  out_send_type;
  logic [31:0] out_send_session;
  logic [31:0] out_send_run;
  logic [15:0] out_send_completed;
  logic        out_delivered;
  logic [1:0]  out_delivery_result;
  logic [31:0] out_delivery_run;
  logic [3:0]  out_queued;
  logic        out_awaiting_ack;
  logic        cfg_we            = 1'b0;
  logic        cfg_index         = 1'b0;
  logic [31:0] cfg_data          = '0;

  // sender model state
  swes_pkg::entry_t ring_model [DEPTH];
  int          head_model;
  int          fill_model;
  logic        pending_model;
  logic [31:0] last_send_model;
  logic [31:0] interval_model;
  logic [31:0] retry_reg;
  logic [31:0] nack_reg;
  logic [31:0] clock_ms;
  outcome_t    outcomes_due [$];
  outcome_t    oldest_due;

  bit steady        = 1'b0;
  bit valid_held    = 1'b0;
  int sender_gap    = 0;
  int rx_gap        = 0;
  int rx_hold_off   = 0;
  int enqueue_share = 35;
  int errors        = 0;
  int beats_sent    = 0;
  int regs_written  = 0;
  int stored_seen   = 0;
  int sends_seen    = 0;
  int outcomes_seen = 0;

  stop_and_wait_event_sender uut (.*);

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] w;
    w = $urandom;
    return (w == '0) ? 32'd1 : w;
  endfunction

  function automatic beat_t noise_beat(input logic [1:0] opcode, input logic [31:0] now_ms);
    beat_t b;
    b.opcode         = opcode;
    b.now_ms         = now_ms;
    b.event_type     = 2'($urandom);
    b.session_id     = $urandom;
    b.run_id         = $urandom;
    b.completed_runs = 16'($urandom);
    b.reply_kind     = 2'($urandom);
    return b;
  endfunction

  function automatic beat_t event_beat(input logic [31:0] now_ms, input logic [1:0] event_type,
                                       input logic [31:0] session_id, input logic [31:0] run_id,
                                       input logic [15:0] completed_runs);
    beat_t b;
    b = noise_beat(swes_pkg::OP_ENQUEUE, now_ms);
    b.event_type     = event_type;
    b.session_id     = session_id;
    b.run_id         = run_id;
    b.completed_runs = completed_runs;
    return b;
  endfunction

  function automatic beat_t tick_beat(input logic [31:0] now_ms);
    return noise_beat(swes_pkg::OP_TICK, now_ms);
  endfunction

  function automatic beat_t reply_beat(input logic [31:0] now_ms, input logic [31:0] run_id,
                                       input logic [1:0] reply_kind);
    beat_t b;
    b = noise_beat(swes_pkg::OP_REPLY, now_ms);
    b.run_id     = run_id;
    b.reply_kind = reply_kind;
    return b;
  endfunction

  function automatic outcome_t predict_outcome(input beat_t b);
    outcome_t    o;
    int          tail;
    logic [31:0] elapsed;
    o = '0;
    case (b.opcode)
      swes_pkg::OP_ENQUEUE: begin
        if (b.event_type != EV_NONE && b.event_type != EV_INVALID && b.session_id != '0 &&
            b.run_id != '0 && fill_model < DEPTH) begin
          tail = (head_model + fill_model) % DEPTH;
          ring_model[tail] = '{event_type: b.event_type, completed_runs: b.completed_runs,
                               session_id: b.session_id, run_id: b.run_id};
          fill_model++;
          o.enqueue_accepted = 1'b1;
        end
      end
      swes_pkg::OP_TICK: begin
        elapsed = b.now_ms - last_send_model;
        if (fill_model == 0) begin
          pending_model = 1'b0;
        end else if (!pending_model || elapsed >= interval_model) begin
          o.send_now       = 1'b1;
          o.send_type      = ring_model[head_model].event_type;
          o.send_session   = ring_model[head_model].session_id;
          o.send_run       = ring_model[head_model].run_id;
          o.send_completed = ring_model[head_model].completed_runs;
          pending_model    = 1'b1;
          last_send_model  = b.now_ms;
        end
      end
      swes_pkg::OP_REPLY: begin
        if (fill_model != 0 && b.run_id != '0 && b.run_id == ring_model[head_model].run_id &&
            b.reply_kind != swes_pkg::RK_IGNORE) begin
          o.delivered       = 1'b1;
          o.delivery_result = b.reply_kind;
          o.delivery_run    = b.run_id;
          if (b.reply_kind == swes_pkg::RK_NACK) begin
            pending_model  = 1'b1;
            interval_model = nack_reg;
          end else begin
            head_model     = (head_model + 1) % DEPTH;
            fill_model--;
            pending_model  = 1'b0;
            interval_model = retry_reg;
          end
          last_send_model = b.now_ms;
        end
      end
      default: ;
    endcase
    o.queued       = 4'(fill_model);
    o.awaiting_ack = pending_model;
    return o;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 3000);
      6:       clock_ms = last_send_model + interval_model - 1;
      7:       clock_ms = last_send_model + interval_model;
      8:       clock_ms = $urandom;
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < enqueue_share) begin
      b = event_beat(clock_ms,
                     2'($urandom_range(swes_pkg::EV_RUN_STARTED, swes_pkg::EV_RUN_COMPLETED)),
                     nonzero_word(), nonzero_word(), 16'($urandom));
      case ($urandom_range(0, 19))
        0:       b.event_type = EV_NONE;
        1:       b.event_type = EV_INVALID;
        2:       b.session_id = '0;
        3:       b.run_id = '0;
        default: ;
      endcase
    end else if (pick < enqueue_share + 30) begin
      b = tick_beat(clock_ms);
    end else if (pick < 95) begin
      b = reply_beat(clock_ms, nonzero_word(), swes_pkg::RK_ACK);
      if (fill_model != 0 && $urandom_range(0, 9) < 8)
        b.run_id = ring_model[head_model].run_id;
      else if ($urandom_range(0, 3) == 0)
        b.run_id = '0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b.reply_kind = swes_pkg::RK_ACK;
        4, 5:       b.reply_kind = swes_pkg::RK_DUPLICATE;
        6, 7, 8:    b.reply_kind = swes_pkg::RK_NACK;
        default:    b.reply_kind = swes_pkg::RK_IGNORE;
      endcase
    end else begin
      b = noise_beat(OP_UNUSED, clock_ms);
    end
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input bit last_beat);
    if (!valid_held)
      repeat (1 + sender_gap) @(posedge clk);
    in_valid          <= 1'b1;
    in_opcode         <= b.opcode;
    in_now_ms         <= b.now_ms;
    in_event_type     <= b.event_type;
    in_session_id     <= b.session_id;
    in_run_id         <= b.run_id;
    in_completed_runs <= b.completed_runs;
    in_reply_kind     <= b.reply_kind;
    do @(posedge clk); while (in_ready !== 1'b1);
    outcomes_due.push_back(predict_outcome(b));
    beats_sent++;
    sender_gap = pick_gap();
    valid_held = !last_beat && sender_gap == 0;
    if (!valid_held)
      in_valid <= 1'b0;
  endtask

  task automatic wait_for_outcomes();
    while (outcomes_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == swes_pkg::REG_RETRY_INTERVAL)
      retry_reg = data;
    else
      nack_reg = data;
    regs_written++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
    end
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold_off > 0) begin
      rx_hold_off--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result beat at %0t with nothing expected", $time);
      end else begin
        oldest_due = outcomes_due.pop_front();
        compare_field("enqueue_accepted", 32'(oldest_due.enqueue_accepted),
                      32'(out_enqueue_accepted));
        compare_field("send_now", 32'(oldest_due.send_now), 32'(out_send_now));
        compare_field("send_type", 32'(oldest_due.send_type), 32'(out_send_type));
        compare_field("send_session", oldest_due.send_session, out_send_session);
        compare_field("send_run", oldest_due.send_run, out_send_run);
        compare_field("send_completed", 32'(oldest_due.send_completed),
                      32'(out_send_completed));
        compare_field("delivered", 32'(oldest_due.delivered), 32'(out_delivered));
        compare_field("delivery_result", 32'(oldest_due.delivery_result),
                      32'(out_delivery_result));
        compare_field("delivery_run", oldest_due.delivery_run, out_delivery_run);
        compare_field("queued", 32'(oldest_due.queued), 32'(out_queued));
        compare_field("awaiting_ack", 32'(oldest_due.awaiting_ack), 32'(out_awaiting_ack));
        stored_seen   += int'(oldest_due.enqueue_accepted);
        sends_seen    += int'(oldest_due.send_now);
        outcomes_seen += int'(oldest_due.delivered);
      end
    end
  end

  task automatic test_empty_queue();
    send_beat(tick_beat(32'd0), 1'b0);
    send_beat(reply_beat(32'd0, 32'd5, swes_pkg::RK_ACK), 1'b0);
  endtask

  task automatic test_refused_events();
    send_beat(event_beat(32'd1, EV_NONE, 32'd1, 32'd1, 16'd1), 1'b0);
    send_beat(event_beat(32'd2, EV_INVALID, 32'd1, 32'd1, 16'd1), 1'b0);
    send_beat(event_beat(32'd3, swes_pkg::EV_RUN_STARTED, 32'd0, 32'd1, 16'd1), 1'b0);
    send_beat(event_beat(32'd4, swes_pkg::EV_RUN_COMPLETED, 32'd1, 32'd0, 16'd1), 1'b0);
  endtask

  task automatic test_full_queue();
    send_beat(event_beat(32'd5, swes_pkg::EV_RUN_STARTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'hFFFF), 1'b0);
    send_beat(event_beat(32'd6, swes_pkg::EV_RUN_COMPLETED, 32'd1, 32'd2, 16'd0), 1'b0);
    for (int i = 0; i < DEPTH - 2; i++)
      send_beat(event_beat($urandom, swes_pkg::EV_RUN_COMPLETED, nonzero_word(),
                           nonzero_word(), 16'($urandom)), 1'b0);
    send_beat(event_beat(32'd7, swes_pkg::EV_RUN_STARTED, 32'd7, 32'd7, 16'd7), 1'b0);
  endtask

  task automatic test_retransmit();
    send_beat(tick_beat(T0), 1'b0);
    send_beat(tick_beat(T0 + 32'd999), 1'b0);
    send_beat(tick_beat(T0 + 32'd1000), 1'b0);
  endtask

  task automatic test_replies();
    send_beat(reply_beat(T0 + 32'd1100, 32'd2, swes_pkg::RK_ACK), 1'b0);
    send_beat(reply_beat(T0 + 32'd1200, 32'd0, swes_pkg::RK_ACK), 1'b0);
    send_beat(reply_beat(T0 + 32'd1300, 32'hFFFF_FFFF, swes_pkg::RK_IGNORE), 1'b0);
    send_beat(reply_beat(T0 + 32'd1500, 32'hFFFF_FFFF, swes_pkg::RK_NACK), 1'b0);
    send_beat(tick_beat(T0 + 32'd3499), 1'b0);
    send_beat(tick_beat(T0 + 32'd3500), 1'b0);
    send_beat(reply_beat(T0 + 32'd3600, 32'hFFFF_FFFF, swes_pkg::RK_DUPLICATE), 1'b0);
    send_beat(reply_beat(T0 + 32'd3700, 32'd2, swes_pkg::RK_ACK), 1'b0);
    clock_ms = T0 + 32'd3700;
  endtask

  task automatic test_unknown_opcode();
    send_beat(noise_beat(OP_UNUSED, $urandom), 1'b1);
    wait_for_outcomes();
  endtask

  task automatic test_backpressure();
    steady      = 1'b1;
    rx_hold_off = 200;
    for (int i = 0; i < 24; i++)
      send_beat(random_beat(), i == 23);
    wait_for_outcomes();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [31:0] retry_set [6];
    logic [31:0] nack_set [6];
    bit          pause;
    retry_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd250,
                  swes_pkg::RETRY_INTERVAL_RESET, 32'd0};
    nack_set  = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd4000,
                  swes_pkg::NACK_RETRY_INTERVAL_RESET, 32'd0};
    retry_set[5] = $urandom_range(1, 5000);
    nack_set[5]  = $urandom_range(1, 8000);
    for (int p = 0; p < 6; p++) begin
      wait_for_outcomes();
      write_register(swes_pkg::REG_RETRY_INTERVAL, retry_set[p]);
      write_register(swes_pkg::REG_NACK_RETRY_INTERVAL, nack_set[p]);
      steady        = (p % 3 == 2);
      enqueue_share = (p % 2 == 0) ? 40 : 15;
      for (int i = 0; i < 145; i++) begin
        pause = ($urandom_range(0, 49) == 0) || i == 144;
        send_beat(random_beat(), pause);
        if (pause)
          wait_for_outcomes();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    retry_reg       = swes_pkg::RETRY_INTERVAL_RESET;
    nack_reg        = swes_pkg::NACK_RETRY_INTERVAL_RESET;
    interval_model  = swes_pkg::RETRY_INTERVAL_RESET;
    head_model      = 0;
    fill_model      = 0;
    pending_model   = 1'b0;
    last_send_model = '0;
    clock_ms        = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_refused_events();
    test_full_queue();
    test_retransmit();
    test_replies();
    test_unknown_opcode();
    test_backpressure();
    test_random_traffic();
    wait_for_outcomes();
    $display("Sent %0d beats across %0d register writes, incl. a long output hold-off.",
             beats_sent, regs_written);
    $display("Checked %0d stored events, %0d transmissions and %0d delivery outcomes.",
             stored_seen, sends_seen, outcomes_seen);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
